### design/msl_pkg.sv
// Shared types, field widths and register indexes of the master/stack tile layout block.
`default_nettype none

package msl_pkg;

    // Default cap on the number of tiled windows.
    localparam int unsigned MAX_WINDOWS_DEF = 128;

    // Field widths.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned DIM_W      = 15;
    localparam int unsigned GAP_W      = 8;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned IDX_W      = 7;
    localparam int unsigned OFF_W      = 17;
    localparam int unsigned WIN_POS_W  = 17;
    localparam int unsigned WIN_WID_W  = 16;
    localparam int unsigned HEIGHT_W   = 15;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AREA_X          = 3'd0,
        REG_AREA_Y          = 3'd1,
        REG_AREA_WIDTH      = 3'd2,
        REG_AREA_HEIGHT     = 3'd3,
        REG_GAP             = 3'd4,
        REG_MASTER_COUNT    = 3'd5,
        REG_MASTER_FRACTION = 3'd6,
        REG_WINDOW_COUNT    = 3'd7
    } msl_reg_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [POS_W-1:0]  area_x;
        logic [POS_W-1:0]  area_y;
        logic [DIM_W-1:0]  area_width;
        logic [DIM_W-1:0]  area_height;
        logic [GAP_W-1:0]  gap;
        logic [CNT_W-1:0]  master_count;
        logic [FRAC_W-1:0] master_fraction;
        logic [CNT_W-1:0]  window_count;
    } msl_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic prep;
        logic calc;
        logic div_start;
        logic finish;
    } msl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_valid;
        logic div_done;
        logic out_free;
    } msl_sts_t;

endpackage

`default_nettype wire

### design/msl_cfg.sv
// Configuration register file of the tile layout block.
`default_nettype none

module msl_cfg (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [msl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [msl_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    output msl_pkg::msl_cfg_t                  cfg
);

    msl_pkg::msl_cfg_t cfg_reg;
    msl_pkg::msl_cfg_t cfg_next;

    // Decode the write index and update one register.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (msl_pkg::msl_reg_t'(cfg_index))
                msl_pkg::REG_AREA_X: begin
                    cfg_next.area_x = cfg_wr_data;
                end
                msl_pkg::REG_AREA_Y: begin
                    cfg_next.area_y = cfg_wr_data;
                end
                msl_pkg::REG_AREA_WIDTH: begin
                    cfg_next.area_width = cfg_wr_data[msl_pkg::DIM_W-1:0];
                end
                msl_pkg::REG_AREA_HEIGHT: begin
                    cfg_next.area_height = cfg_wr_data[msl_pkg::DIM_W-1:0];
                end
                msl_pkg::REG_GAP: begin
                    cfg_next.gap = cfg_wr_data[msl_pkg::GAP_W-1:0];
                end
                msl_pkg::REG_MASTER_COUNT: begin
                    cfg_next.master_count = cfg_wr_data[msl_pkg::CNT_W-1:0];
                end
                msl_pkg::REG_MASTER_FRACTION: begin
                    cfg_next.master_fraction = cfg_wr_data;
                end
                msl_pkg::REG_WINDOW_COUNT: begin
                    cfg_next.window_count = cfg_wr_data[msl_pkg::CNT_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // Registers with their reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.area_x          <= 16'd0;
            cfg_reg.area_y          <= 16'd0;
            cfg_reg.area_width      <= 15'd1920;
            cfg_reg.area_height     <= 15'd1080;
            cfg_reg.gap             <= 8'd0;
            cfg_reg.master_count    <= 8'd1;
            cfg_reg.master_fraction <= 16'd32768;
            cfg_reg.window_count    <= 8'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/msl_div.sv
// Iterative restoring divider for the column height split, one quotient bit per cycle.
`default_nettype none

module msl_div (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             start,
    input  wire  [msl_pkg::HEIGHT_W-1:0]    dividend,
    input  wire  [msl_pkg::CNT_W-1:0]       divisor,
    output logic [msl_pkg::HEIGHT_W-1:0]    quotient,
    output logic                            done
);

    localparam int unsigned Steps = msl_pkg::HEIGHT_W;
    localparam int unsigned CntW  = $clog2(Steps + 1);
    localparam int unsigned DvW   = msl_pkg::CNT_W;

    logic [CntW-1:0]                  count_reg, count_next;
    logic                             done_reg, done_next;
    logic [DvW-1:0]                   rem_reg, rem_next;
    logic [msl_pkg::HEIGHT_W-1:0]     quo_reg, quo_next;
    logic [DvW-1:0]                   den_reg, den_next;
    logic [DvW:0]                     trial;
    logic                             fits;

    // One restoring step: shift in the next dividend bit and try a subtraction.
    always_comb begin
        trial      = {rem_reg, quo_reg[msl_pkg::HEIGHT_W-1]};
        fits       = trial >= {1'b0, den_reg};
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        if (start) begin
            count_next = CntW'(Steps);
            rem_next   = '0;
            quo_next   = dividend;
            den_next   = divisor;
        end else if (count_reg != '0) begin
            count_next = count_reg - 1'b1;
            done_next  = count_reg == CntW'(1);
            if (fits) begin
                rem_next = DvW'(trial - {1'b0, den_reg});
            end else begin
                rem_next = trial[DvW-1:0];
            end
            quo_next = {quo_reg[msl_pkg::HEIGHT_W-2:0], fits};
        end
    end

    // Control state is reset; the working registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

### design/msl_dp.sv
// Datapath of the tile layout block: column selection, widths, heights and running offsets.
`default_nettype none

module msl_dp #(
    parameter int unsigned MAX_WINDOWS = msl_pkg::MAX_WINDOWS_DEF
) (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire msl_pkg::msl_cfg_t                  cfg,
    input  wire msl_pkg::msl_cmd_t                  cmd,
    output msl_pkg::msl_sts_t                       sts,
    input  wire  [msl_pkg::IDX_W-1:0]               s_window_index,
    input  wire                                     m_ready,
    output logic                                    m_valid,
    output logic signed [msl_pkg::WIN_POS_W-1:0]    m_win_x,
    output logic signed [msl_pkg::WIN_POS_W-1:0]    m_win_y,
    output logic signed [msl_pkg::WIN_WID_W-1:0]    m_win_width,
    output logic [msl_pkg::HEIGHT_W-1:0]            m_win_height,
    output logic                                    m_in_master
);

    localparam int unsigned CntW     = msl_pkg::CNT_W;
    localparam int unsigned OffW     = msl_pkg::OFF_W;
    localparam int unsigned HW       = msl_pkg::HEIGHT_W;
    localparam int unsigned CapCount = (MAX_WINDOWS > 255) ? 255 : MAX_WINDOWS;
    localparam logic [CntW-1:0] CapCnt = CntW'(CapCount);

    // Item registers.
    logic [msl_pkg::IDX_W-1:0]  idx_reg;
    logic                       master_reg;
    logic                       last_reg;
    logic                       split_reg;
    logic [CntW-1:0]            den_reg;
    logic [OffW-1:0]            off_reg;
    logic signed [18:0]         num_reg;
    logic signed [18:0]         tail_reg;
    logic signed [32:0]         prod_reg;
    logic [OffW-1:0]            moff_reg, moff_next;
    logic [OffW-1:0]            soff_reg, soff_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [16:0]         win_x_reg;
    logic signed [16:0]         win_y_reg;
    logic signed [15:0]         win_width_reg;
    logic [HW-1:0]              win_height_reg;
    logic                       in_master_reg;

    // Column counts and placement of the captured index.
    logic [CntW-1:0]  n_cnt, nm_cnt, ns_cnt, idx_ext, den_sel;
    logic             item_valid, is_master, is_last, is_first;
    logic [OffW-1:0]  off_sel;

    always_comb begin
        n_cnt      = (cfg.window_count < CapCnt) ? cfg.window_count : CapCnt;
        nm_cnt     = (cfg.master_count < n_cnt) ? cfg.master_count : n_cnt;
        ns_cnt     = n_cnt - nm_cnt;
        idx_ext    = {1'b0, idx_reg};
        item_valid = idx_ext < n_cnt;
        is_master  = idx_ext < nm_cnt;
        is_last    = is_master ? (idx_ext == nm_cnt - 8'd1) : (idx_ext == n_cnt - 8'd1);
        den_sel    = is_master ? nm_cnt : ns_cnt;
        is_first   = idx_reg == '0;
        off_sel    = is_first ? '0 : (is_master ? moff_reg : soff_reg);
    end

    // Even split numerator, last-window remainder and master width product.
    logic [16:0]         gden;
    logic signed [18:0]  num_calc;
    logic signed [18:0]  tail_calc;
    logic signed [15:0]  wg;
    logic signed [16:0]  frac_s;
    logic signed [32:0]  prod_calc;

    always_comb begin
        gden      = 17'(cfg.gap) * 17'({1'b0, den_reg} + 9'd1);
        num_calc  = $signed({4'b0, cfg.area_height}) - $signed({2'b0, gden});
        tail_calc = $signed({4'b0, cfg.area_height}) - $signed({2'b0, off_reg})
                    - $signed({10'b0, cfg.gap, 1'b0});
        wg        = $signed({1'b0, cfg.area_width}) - $signed({8'b0, cfg.gap});
        frac_s    = $signed({1'b0, cfg.master_fraction});
        prod_calc = wg * frac_s;
    end

    // Iterative divider for the even height split.
    logic [HW-1:0] quo;
    logic          div_done;

    msl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num_reg[HW-1:0]),
        .divisor  (den_reg),
        .quotient (quo),
        .done     (div_done)
    );

    // Final rectangle of the window and the updated column offset.
    logic signed [32:0]  mw_sum;
    logic signed [17:0]  mw18, x18, g18, gh18, w18;
    logic signed [17:0]  mx, sx, mwf, swf;
    logic [HW-1:0]       h;
    logic [16:0]         y_out;
    logic [OffW-1:0]     off_new;

    always_comb begin
        mw_sum = prod_reg + 33'sd32768;
        mw18   = {mw_sum[32], mw_sum[32:16]};
        x18    = {{2{cfg.area_x[15]}}, cfg.area_x};
        g18    = {10'b0, cfg.gap};
        gh18   = {11'b0, cfg.gap[7:1]};
        w18    = {3'b0, cfg.area_width};
        mx     = x18 + g18;
        if (split_reg) begin
            mwf = mw18 - g18 - gh18;
            sx  = x18 + mw18 + gh18;
            swf = w18 - mw18 - gh18 - g18;
        end else begin
            mwf = w18 - g18 - g18;
            sx  = mx;
            swf = mwf;
        end
        // Heights are clamped to at least one pixel.
        if (last_reg) begin
            h = (tail_reg < 19'sd1) ? 15'd1 : tail_reg[HW-1:0];
        end else begin
            h = ((num_reg > 19'sd0) && (quo != '0)) ? quo : 15'd1;
        end
        y_out   = {cfg.area_y[15], cfg.area_y} + off_reg + {9'b0, cfg.gap};
        off_new = off_reg + {2'b0, h} + {9'b0, cfg.gap};
    end

    // Offsets and output valid.
    always_comb begin
        moff_next    = moff_reg;
        soff_next    = soff_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.prep && item_valid && is_first) begin
            moff_next = '0;
            soff_next = '0;
        end
        if (cmd.finish) begin
            m_valid_next = 1'b1;
            if (master_reg) begin
                moff_next = off_new;
            end else begin
                soff_next = off_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moff_reg    <= '0;
            soff_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            moff_reg    <= moff_next;
            soff_reg    <= soff_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers, loaded on command.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            idx_reg <= s_window_index;
        end
        if (cmd.prep) begin
            master_reg <= is_master;
            last_reg   <= is_last;
            split_reg  <= (nm_cnt != '0) && (ns_cnt != '0);
            den_reg    <= den_sel;
            off_reg    <= off_sel;
        end
        if (cmd.calc) begin
            num_reg  <= num_calc;
            tail_reg <= tail_calc;
            prod_reg <= prod_calc;
        end
        if (cmd.finish) begin
            win_x_reg      <= master_reg ? mx[16:0] : sx[16:0];
            win_y_reg      <= y_out;
            win_width_reg  <= master_reg ? mwf[15:0] : swf[15:0];
            win_height_reg <= h;
            in_master_reg  <= master_reg;
        end
    end

    assign sts.item_valid = item_valid;
    assign sts.div_done   = div_done;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_win_x      = win_x_reg;
    assign m_win_y      = win_y_reg;
    assign m_win_width  = win_width_reg;
    assign m_win_height = win_height_reg;
    assign m_in_master  = in_master_reg;

endmodule

`default_nettype wire

### design/msl_ctrl.sv
// Controller state machine that sequences one window through the datapath.
`default_nettype none

module msl_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire msl_pkg::msl_sts_t  sts,
    output msl_pkg::msl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CALC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = sts.item_valid ? ST_CALC : ST_IDLE;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;

endmodule

`default_nettype wire

### design/master_stack_tile_layout.sv
// A window passes through the capture, prep, calc, divider start, wait and finish states.
// A new window is taken only in idle, after the last one and its 15-step divide are done.
// An index at or beyond the capped window count gives no result; the input frees after prep.
// The output register lets the next window start while a result waits to be taken.
// Reset (aresetn, synchronous, active low) clears offsets and control and loads the
// default configuration.
`default_nettype none

module master_stack_tile_layout #(
    parameter int unsigned MAX_WINDOWS = msl_pkg::MAX_WINDOWS_DEF
) (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     cfg_wr_en,
    input  wire  [msl_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire  [msl_pkg::CFG_DATA_W-1:0]          cfg_wr_data,
    input  wire                                     s_valid,
    output logic                                    s_ready,
    input  wire  [msl_pkg::IDX_W-1:0]               s_window_index,
    output logic                                    m_valid,
    input  wire                                     m_ready,
    output logic signed [msl_pkg::WIN_POS_W-1:0]    m_win_x,
    output logic signed [msl_pkg::WIN_POS_W-1:0]    m_win_y,
    output logic signed [msl_pkg::WIN_WID_W-1:0]    m_win_width,
    output logic [msl_pkg::HEIGHT_W-1:0]            m_win_height,
    output logic                                    m_in_master
);

    msl_pkg::msl_cfg_t cfg;
    msl_pkg::msl_cmd_t cmd;
    msl_pkg::msl_sts_t sts;

    // Configuration registers.
    msl_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Sequencer.
    msl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Arithmetic and output register.
    msl_dp #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .s_window_index (s_window_index),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_win_x        (m_win_x),
        .m_win_y        (m_win_y),
        .m_win_width    (m_win_width),
        .m_win_height   (m_win_height),
        .m_in_master    (m_in_master)
    );

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the master/stack tile layout block.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 30;
    localparam int unsigned RANDOM_WINDOWS = 1300;

    // One window rectangle as the result channel carries it.
    typedef struct {
        logic signed [msl_pkg::WIN_POS_W-1:0] x;
        logic signed [msl_pkg::WIN_POS_W-1:0] y;
        logic signed [msl_pkg::WIN_WID_W-1:0] width;
        logic [msl_pkg::HEIGHT_W-1:0]         height;
        logic                                 master;
    } win_rect_t;

    // Tracks the layout configuration and column offsets, predicts each window's
    // rectangle and checks the rectangles that come out of the block.
    class layout_tracker;
        logic signed [msl_pkg::POS_W-1:0] area_x;
        logic signed [msl_pkg::POS_W-1:0] area_y;
        logic [msl_pkg::DIM_W-1:0]        area_width;
        logic [msl_pkg::DIM_W-1:0]        area_height;
        logic [msl_pkg::GAP_W-1:0]        gap;
        logic [msl_pkg::CNT_W-1:0]        master_count;
        logic [msl_pkg::FRAC_W-1:0]       master_fraction;
        logic [msl_pkg::CNT_W-1:0]        window_count;
        logic [msl_pkg::OFF_W-1:0]        master_off;
        logic [msl_pkg::OFF_W-1:0]        stack_off;
        win_rect_t                        pending_rects[$];
        int unsigned                      mismatches;

        function new();
            area_x          = '0;
            area_y          = '0;
            area_width      = msl_pkg::DIM_W'(1920);
            area_height     = msl_pkg::DIM_W'(1080);
            gap             = '0;
            master_count    = msl_pkg::CNT_W'(1);
            master_fraction = msl_pkg::FRAC_W'(32768);
            window_count    = msl_pkg::CNT_W'(1);
            master_off      = '0;
            stack_off       = '0;
            mismatches      = 0;
        endfunction

        function void set_reg(msl_pkg::msl_reg_t idx, logic [msl_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                msl_pkg::REG_AREA_X:          area_x = data;
                msl_pkg::REG_AREA_Y:          area_y = data;
                msl_pkg::REG_AREA_WIDTH:      area_width = data[msl_pkg::DIM_W-1:0];
                msl_pkg::REG_AREA_HEIGHT:     area_height = data[msl_pkg::DIM_W-1:0];
                msl_pkg::REG_GAP:             gap = data[msl_pkg::GAP_W-1:0];
                msl_pkg::REG_MASTER_COUNT:    master_count = data[msl_pkg::CNT_W-1:0];
                msl_pkg::REG_MASTER_FRACTION: master_fraction = data;
                msl_pkg::REG_WINDOW_COUNT:    window_count = data[msl_pkg::CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Number of windows taking part, capped by the block's window limit.
        function int unsigned active_windows();
            return (window_count < msl_pkg::MAX_WINDOWS_DEF) ? window_count
                                                             : msl_pkg::MAX_WINDOWS_DEF;
        endfunction

        // Works out the rectangle of an accepted window and queues it.
        function void place_window(logic [msl_pkg::IDX_W-1:0] idx);
            longint    i, n, nm, ns, x, y, w, ha, g, frac;
            longint    mw, mx, mwf, sx, swf, h, off, px, pw, py;
            bit        master;
            win_rect_t r;
            i = idx;
            n = active_windows();
            if (i >= n) return;
            if (i == 0) begin
                master_off = '0;
                stack_off  = '0;
            end
            x    = area_x;
            y    = area_y;
            w    = area_width;
            ha   = area_height;
            g    = gap;
            frac = master_fraction;
            nm   = (master_count < n) ? master_count : n;
            ns   = n - nm;

            // Column geometry: two columns only when both hold windows.
            mx = x + g;
            if (nm > 0 && ns > 0) begin
                mw  = ((w - g) * frac + 32768) >>> 16;
                mwf = mw - g - g / 2;
                sx  = x + mw + g / 2;
                swf = w - mw - g / 2 - g;
            end else begin
                mwf = w - 2 * g;
                sx  = mx;
                swf = mwf;
            end

            // Even split; the last window of a column takes the remainder.
            master = (i < nm);
            if (master) begin
                off = master_off;
                h = (i == nm - 1) ? (ha - off - 2 * g) : ((ha - g * (nm + 1)) / nm);
            end else begin
                off = stack_off;
                h = (i == n - 1) ? (ha - off - 2 * g) : ((ha - g * (ns + 1)) / ns);
            end
            if (h < 1) h = 1;

            px = master ? mx : sx;
            pw = master ? mwf : swf;
            py = y + off + g;
            r.x      = px[msl_pkg::WIN_POS_W-1:0];
            r.y      = py[msl_pkg::WIN_POS_W-1:0];
            r.width  = pw[msl_pkg::WIN_WID_W-1:0];
            r.height = h[msl_pkg::HEIGHT_W-1:0];
            r.master = master;
            pending_rects.push_back(r);

            if (master) master_off = msl_pkg::OFF_W'(off + h + g);
            else stack_off = msl_pkg::OFF_W'(off + h + g);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Checks one rectangle against the oldest prediction.
        function void check_rect(win_rect_t got);
            win_rect_t want;
            if (pending_rects.size() == 0) begin
                $error("rectangle transfer with no window pending");
                mismatches++;
                return;
            end
            want = pending_rects.pop_front();
            compare_field("win_x", want.x, got.x);
            compare_field("win_y", want.y, got.y);
            compare_field("win_width", want.width, got.width);
            compare_field("win_height", {17'd0, want.height}, {17'd0, got.height});
            compare_field("in_master", {31'd0, want.master}, {31'd0, got.master});
        endfunction
    endclass

    logic                                   aclk = 1'b0;
    logic                                   aresetn = 1'b0;
    logic                                   cfg_wr_en = 1'b0;
    logic [msl_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
    logic [msl_pkg::CFG_DATA_W-1:0]         cfg_wr_data = '0;
    logic                                   s_valid = 1'b0;
    logic                                   s_ready;
    logic [msl_pkg::IDX_W-1:0]              s_window_index = '0;
    logic                                   m_valid;
    logic                                   m_ready = 1'b0;
    logic signed [msl_pkg::WIN_POS_W-1:0]   m_win_x;
    logic signed [msl_pkg::WIN_POS_W-1:0]   m_win_y;
    logic signed [msl_pkg::WIN_WID_W-1:0]   m_win_width;
    logic [msl_pkg::HEIGHT_W-1:0]           m_win_height;
    logic                                   m_in_master;

    layout_tracker                          tracker;
    logic [msl_pkg::CFG_DATA_W-1:0]         next_cfg [8];
    win_rect_t                              seen_rect;
    bit                                     steady = 1'b0;
    int unsigned                            placed_windows = 0;
    int unsigned                            ready_hold = 0;
    int unsigned                            stuck_cycles = 0;

    master_stack_tile_layout u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_window_index (s_window_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_win_x        (m_win_x),
        .m_win_y        (m_win_y),
        .m_win_width    (m_win_width),
        .m_win_height   (m_win_height),
        .m_in_master    (m_in_master)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int unsigned pause_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(21, 80);
    endfunction

    // Result side back-pressure.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < 15) begin
            ready_hold <= pause_length();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watch both channels: predict on each input transfer, check each result transfer.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) tracker.place_window(s_window_index);
        if (aresetn && m_valid && m_ready) begin
            seen_rect.x      = m_win_x;
            seen_rect.y      = m_win_y;
            seen_rect.width  = m_win_width;
            seen_rect.height = m_win_height;
            seen_rect.master = m_in_master;
            tracker.check_rect(seen_rect);
        end
    end

    // Give up when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Offers one window index and returns at the edge of its transfer.
    task automatic push_window(input logic [msl_pkg::IDX_W-1:0] idx);
        int unsigned pause;
        pause = pause_length();
        if (idx < tracker.active_windows()) placed_windows++;
        if (pause != 0) begin
            s_valid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_window_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drops valid, waits for every predicted rectangle, then lets the block go quiet.
    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_rects.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes every register, or a random subset, from next_cfg.
    task automatic write_config(input bit every_reg);
        msl_pkg::msl_reg_t r;
        r = r.first();
        repeat (r.num()) begin
            if (every_reg || $urandom_range(0, 2) != 0) begin
                cfg_wr_en <= 1'b1;
                cfg_index <= r;
                cfg_wr_data <= next_cfg[r];
                @(posedge aclk);
                tracker.set_reg(r, next_cfg[r]);
            end
            r = r.next();
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void set_layout(logic [15:0] ax, logic [15:0] ay, logic [15:0] aw,
                                       logic [15:0] ah, logic [15:0] g, logic [15:0] mc,
                                       logic [15:0] frac, logic [15:0] wc);
        next_cfg[msl_pkg::REG_AREA_X]          = ax;
        next_cfg[msl_pkg::REG_AREA_Y]          = ay;
        next_cfg[msl_pkg::REG_AREA_WIDTH]      = aw;
        next_cfg[msl_pkg::REG_AREA_HEIGHT]     = ah;
        next_cfg[msl_pkg::REG_GAP]             = g;
        next_cfg[msl_pkg::REG_MASTER_COUNT]    = mc;
        next_cfg[msl_pkg::REG_MASTER_FRACTION] = frac;
        next_cfg[msl_pkg::REG_WINDOW_COUNT]    = wc;
    endfunction

    // Now and then sets the unused upper bits of a narrow register write.
    function automatic logic [msl_pkg::CFG_DATA_W-1:0] with_junk(
        logic [msl_pkg::CFG_DATA_W-1:0] v, int unsigned w);
        logic [msl_pkg::CFG_DATA_W-1:0] keep;
        keep = (msl_pkg::CFG_DATA_W'(1) << w) - msl_pkg::CFG_DATA_W'(1);
        if ($urandom_range(0, 9) == 0) begin
            return (v & keep) | (msl_pkg::CFG_DATA_W'($urandom()) & ~keep);
        end
        return v;
    endfunction

    function automatic logic [msl_pkg::CFG_DATA_W-1:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            1: return msl_pkg::CFG_DATA_W'($urandom_range(0, 4000) - 2000);
            default: return msl_pkg::CFG_DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [msl_pkg::CFG_DATA_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return with_junk(msl_pkg::CFG_DATA_W'($urandom_range(1, 4096)),
                                     msl_pkg::DIM_W);
        if (r < 88) return with_junk(msl_pkg::CFG_DATA_W'($urandom_range(1, 16384)),
                                     msl_pkg::DIM_W);
        if (r < 93) return msl_pkg::CFG_DATA_W'(16384);
        if (r < 96) return msl_pkg::CFG_DATA_W'(1);
        return msl_pkg::CFG_DATA_W'($urandom_range(0, 32767));
    endfunction

    // Random layout, biased toward small window counts and modest gaps.
    function automatic void random_layout();
        int unsigned r, wc, mc, g;
        r = $urandom_range(0, 99);
        if (r < 55) wc = $urandom_range(1, 8);
        else if (r < 75) wc = $urandom_range(9, 32);
        else if (r < 88) wc = $urandom_range(33, 127);
        else if (r < 94) wc = msl_pkg::MAX_WINDOWS_DEF;
        else if (r < 97) wc = $urandom_range(129, 255);
        else wc = 0;

        r = $urandom_range(0, 99);
        if (r < 15) mc = 0;
        else if (r < 65) mc = $urandom_range(1, 4);
        else if (r < 85) mc = $urandom_range(0, wc);
        else if (r < 95) mc = $urandom_range(0, 255);
        else mc = $urandom_range(0, 1) ? 128 : 255;

        r = $urandom_range(0, 99);
        if (r < 50) g = $urandom_range(0, 16);
        else if (r < 80) g = $urandom_range(0, 64);
        else if (r < 95) g = $urandom_range(0, 255);
        else g = 255;

        next_cfg[msl_pkg::REG_AREA_X]       = pick_coord();
        next_cfg[msl_pkg::REG_AREA_Y]       = pick_coord();
        next_cfg[msl_pkg::REG_AREA_WIDTH]   = pick_dim();
        next_cfg[msl_pkg::REG_AREA_HEIGHT]  = pick_dim();
        next_cfg[msl_pkg::REG_GAP]          = with_junk(msl_pkg::CFG_DATA_W'(g),
                                                        msl_pkg::GAP_W);
        next_cfg[msl_pkg::REG_MASTER_COUNT] = with_junk(msl_pkg::CFG_DATA_W'(mc),
                                                        msl_pkg::CNT_W);
        next_cfg[msl_pkg::REG_WINDOW_COUNT] = with_junk(msl_pkg::CFG_DATA_W'(wc),
                                                        msl_pkg::CNT_W);

        r = $urandom_range(0, 99);
        if (r < 80) begin
            next_cfg[msl_pkg::REG_MASTER_FRACTION] =
                msl_pkg::CFG_DATA_W'($urandom_range(6554, 58982));
        end else if (r < 85) begin
            next_cfg[msl_pkg::REG_MASTER_FRACTION] = msl_pkg::CFG_DATA_W'(6554);
        end else if (r < 90) begin
            next_cfg[msl_pkg::REG_MASTER_FRACTION] = msl_pkg::CFG_DATA_W'(58982);
        end else begin
            next_cfg[msl_pkg::REG_MASTER_FRACTION] = msl_pkg::CFG_DATA_W'($urandom());
        end
    endfunction

    // Sends windows 0 .. count-1 in order; a full count is one whole arrangement.
    task automatic send_run(input int unsigned count);
        for (int i = 0; i < count; i++) push_window(msl_pkg::IDX_W'(i));
    endtask

    // Repeated, out-of-order, out-of-range and restarting indices.
    task automatic send_noise();
        int unsigned n;
        n = tracker.active_windows();
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 3))
                0: push_window(msl_pkg::IDX_W'($urandom_range(0, 127)));
                1: push_window((n > 0) ? msl_pkg::IDX_W'($urandom_range(0, n - 1)) : '0);
                2: push_window(msl_pkg::IDX_W'(n + $urandom_range(0, 3)));
                default: push_window('0);
            endcase
        end
    endtask

    initial begin
        tracker = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset layout: a single window, an index past the count, and a restart.
        push_window(7'd0);
        push_window(7'd127);
        push_window(7'd0);
        settle_block();

        // Most negative origin, a 16384 by 16384 area, largest gap, two masters and three stacked,
        // then a repeated and an out-of-order index.
        set_layout(16'h8000, 16'h8000, 16'd16384, 16'd16384, 16'd255, 16'd2, 16'd58982, 16'd5);
        write_config(1'b1);
        send_run(5);
        push_window(7'd2);
        push_window(7'd1);
        settle_block();

        // Gap larger than a one-pixel area with no masters: negative sizes pass through.
        set_layout(16'h7fff, 16'h7fff, 16'd1, 16'd1, 16'd255, 16'd0, 16'd6554, 16'd3);
        write_config(1'b1);
        send_run(3);
        settle_block();

        // Zero window count: nothing is placed.
        set_layout(16'd0, 16'd0, 16'd1920, 16'd1080, 16'd0, 16'd4, 16'd32768, 16'd0);
        write_config(1'b1);
        push_window(7'd0);
        push_window(7'd127);
        settle_block();

        // Count above the cap, every window a master, zero fraction, widest area.
        set_layout(16'd100, 16'd50, 16'd32767, 16'd32767, 16'd16, 16'd255, 16'd0, 16'd255);
        write_config(1'b1);
        push_window(7'd0);
        push_window(7'd127);
        settle_block();

        // Full fraction, heights clamped to one, upper bits set in narrow registers.
        set_layout(16'hffff, 16'hffff, 16'hc000, 16'd1, 16'hff03, 16'hff03, 16'hffff, 16'd5);
        write_config(1'b1);
        send_run(5);
        settle_block();

        // Random layouts: mostly whole arrangements, some cut short or scrambled.
        placed_windows = 0;
        while (placed_windows < RANDOM_WINDOWS) begin
            random_layout();
            write_config($urandom_range(0, 3) == 0);
            steady = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 9))
                    0: send_noise();
                    1: begin
                        send_run($urandom_range(0, tracker.active_windows()));
                        send_noise();
                    end
                    default: send_run(tracker.active_windows());
                endcase
            end
            settle_block();
        end
        steady = 1'b0;

        settle_block();
        if (tracker.mismatches == 0 && tracker.pending_rects.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
design/msl_pkg.sv
design/msl_cfg.sv
design/msl_div.sv
design/msl_dp.sv
design/msl_ctrl.sv
design/master_stack_tile_layout.sv
sim/tb_top.sv
